FILE: rtl/core/uams_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the undirected adjacency matrix store.
// No dependencies; used by uams_front, uams_back and the top level.
package uams_pkg;

    // Defaults for the top level parameters
    localparam int NODES_DEF       = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed field widths of the stream payloads
    localparam int KIND_W   = 3;
    localparam int NODE_W   = 4;
    localparam int WIN_W    = 16;
    localparam int WOUT_W   = 16;
    localparam int TOTAL_W  = 8;
    localparam int ACTIVE_W = 5;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    // A neighbor listing stops after this many hits
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Request kinds as they arrive on the stream
    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GET = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NBR = 3'd4;

    // Register index of active_nodes
    localparam logic REG_ACTIVE = 1'b0;

    // Classified operation handed to the back end
    typedef enum logic [2:0] {
        OP_ADD,
        OP_DEL,
        OP_SET,
        OP_GET,
        OP_NBR,
        OP_BAD,
        OP_UNK
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [WIN_W-1:0]  weight;
    } req_t;

    typedef struct packed {
        logic               edge_present;
        logic [WOUT_W-1:0]  weight_out;
        logic               neighbor_valid;
        logic [NODE_W-1:0]  neighbor_node;
        logic [TOTAL_W-1:0] edge_total;
        logic               bad_node;
        logic               last;
    } res_t;

endpackage

FILE: rtl/core/uams_front.sv
`timescale 1ns / 1ps
// Front end: accepts request transactions, range-checks nodes, classifies
// the kind and queues the request for the back end. Depends on uams_pkg.
module uams_front #(
    parameter int NODES = uams_pkg::NODES_DEF,
    localparam int LW = $clog2(NODES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [LW-1:0]                 lim,
    input  logic                          hold,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [uams_pkg::KIND_W-1:0]   s_tuser,   // kind
    input  logic [23:0]                   s_tdata,   // node_a, node_b, weight_in
    output logic                          q_valid,
    output uams_pkg::req_t                q_item,
    input  logic                          q_pop
);

    localparam int QD = uams_pkg::QDEPTH;
    localparam int PW = uams_pkg::QPTR_W;
    localparam int CW = uams_pkg::QCNT_W;

    logic [uams_pkg::KIND_W-1:0] kind;
    logic [uams_pkg::NODE_W-1:0] node_a;
    logic [uams_pkg::NODE_W-1:0] node_b;
    logic [uams_pkg::WIN_W-1:0]  weight_in;
    logic                        bad_a;
    logic                        bad_b;
    uams_pkg::req_t              req;
    logic                        push;

    uams_pkg::req_t q_mem [QD];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign kind      = s_tuser;
    assign node_a    = s_tdata[3:0];
    assign node_b    = s_tdata[7:4];
    assign weight_in = s_tdata[23:8];

    assign bad_a = 32'(node_a) >= 32'(lim);
    assign bad_b = 32'(node_b) >= 32'(lim);

    always_comb
    begin
        req.node_a = node_a;
        req.node_b = node_b;
        req.weight = weight_in;
        priority if (kind > uams_pkg::KIND_NBR)
        begin
            req.op = uams_pkg::OP_UNK;
        end
        else if (bad_a || (kind != uams_pkg::KIND_NBR && bad_b))
        begin
            req.op = uams_pkg::OP_BAD;
        end
        else
        begin
            unique case (kind)
                uams_pkg::KIND_ADD: req.op = uams_pkg::OP_ADD;
                uams_pkg::KIND_DEL: req.op = uams_pkg::OP_DEL;
                uams_pkg::KIND_SET: req.op = uams_pkg::OP_SET;
                uams_pkg::KIND_GET: req.op = uams_pkg::OP_GET;
                uams_pkg::KIND_NBR: req.op = uams_pkg::OP_NBR;
                default:            req.op = uams_pkg::OP_UNK;
            endcase
        end
    end

    assign s_tready = (cnt_reg != CW'(QD)) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = cnt_reg != '0;
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QD - 1) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QD - 1) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !(q_pop && q_valid))
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (!push && q_pop && q_valid)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= req;
        end
    end

endmodule

FILE: rtl/core/uams_back.sv
`timescale 1ns / 1ps
// Back end: owns the weight matrix memory and edge counter, clears the
// memory after reset, executes queued requests. Depends on uams_pkg.
module uams_back #(
    parameter int NODES       = uams_pkg::NODES_DEF,
    parameter int WEIGHT_BITS = uams_pkg::WEIGHT_BITS_DEF,
    localparam int LW = $clog2(NODES + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [LW-1:0]  lim,
    output logic           clearing,
    input  logic           q_valid,
    input  uams_pkg::req_t q_item,
    output logic           q_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output uams_pkg::res_t res
);

    localparam int SW = (WEIGHT_BITS < uams_pkg::WIN_W) ? WEIGHT_BITS : uams_pkg::WIN_W;
    localparam int AW = $clog2(NODES * NODES);
    localparam int CW = uams_pkg::CNT_W;
    localparam int TW = uams_pkg::TOTAL_W;
    localparam int NW = uams_pkg::NODE_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(NODES * NODES - 1);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_ONE   = 4'd2;
    localparam logic [3:0] ST_E_RD  = 4'd3;
    localparam logic [3:0] ST_E_CHK = 4'd4;
    localparam logic [3:0] ST_E_WR2 = 4'd5;
    localparam logic [3:0] ST_N_RD  = 4'd6;
    localparam logic [3:0] ST_N_CHK = 4'd7;
    localparam logic [3:0] ST_N_FIN = 4'd8;

    logic [SW-1:0] mem [NODES * NODES];
    logic [SW-1:0] rdata_reg;

    // control state
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [LW-1:0] scan_reg, scan_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          do_wr_reg, do_wr_next;
    logic [TW-1:0] edge_reg, edge_next;
    logic          out_valid_reg;

    // request payload
    uams_pkg::op_t op_reg, op_next;
    logic [AW-1:0] ab_reg, ab_next;
    logic [AW-1:0] ba_reg, ba_next;
    logic [AW-1:0] row_reg, row_next;
    logic [SW-1:0] w_reg, w_next;
    logic [SW-1:0] new_w_reg, new_w_next;
    logic [NW-1:0] pend_node_reg, pend_node_next;
    logic [SW-1:0] pend_w_reg, pend_w_next;
    uams_pkg::res_t out_reg;

    logic           rd_en, wr_en;
    logic [AW-1:0]  raddr, waddr;
    logic [SW-1:0]  wdata;
    logic           slot_free;
    logic           out_load;
    uams_pkg::res_t out_next;
    logic [SW-1:0]  wsel;
    logic [uams_pkg::WOUT_W-1:0] wsel_ext;
    logic [31:0]    scan32;
    logic [NW-1:0]  scan_node;
    logic           hit;
    logic           scan_end;
    logic [SW-1:0]  new_w;
    logic           do_wr;

    assign clearing  = state_reg == ST_CLR;
    assign slot_free = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign scan32    = 32'(scan_reg);
    assign scan_node = scan32[NW-1:0];
    assign hit       = rdata_reg != '0;
    assign scan_end  = (scan_reg + LW'(1)) == lim;

    always_comb
    begin
        wsel_ext         = '0;
        wsel_ext[SW-1:0] = wsel;
    end

    // edit decision on the entry just read
    always_comb
    begin
        new_w = rdata_reg;
        do_wr = 1'b0;
        priority if (op_reg == uams_pkg::OP_ADD ||
                     (op_reg == uams_pkg::OP_SET && rdata_reg == '0))
        begin
            if (rdata_reg == '0 && w_reg != '0)
            begin
                new_w = w_reg;
                do_wr = 1'b1;
            end
        end
        else if (op_reg == uams_pkg::OP_DEL ||
                 (op_reg == uams_pkg::OP_SET && w_reg == '0))
        begin
            if (rdata_reg != '0)
            begin
                new_w = '0;
                do_wr = 1'b1;
            end
        end
        else if (op_reg == uams_pkg::OP_SET)
        begin
            new_w = w_reg;
            do_wr = 1'b1;
        end
        else
        begin
            new_w = rdata_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        scan_next       = scan_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        do_wr_next      = do_wr_reg;
        edge_next       = edge_reg;
        op_next         = op_reg;
        ab_next         = ab_reg;
        ba_next         = ba_reg;
        row_next        = row_reg;
        w_next          = w_reg;
        new_w_next      = new_w_reg;
        pend_node_next  = pend_node_reg;
        pend_w_next     = pend_w_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        raddr           = ab_reg;
        wr_en           = 1'b0;
        waddr           = ab_reg;
        wdata           = '0;
        out_load        = 1'b0;
        wsel            = '0;
        out_next        = '0;

        unique case (state_reg)
            ST_CLR:
            begin
                wr_en = 1'b1;
                waddr = clr_reg;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    op_next         = q_item.op;
                    ab_next  = AW'(32'(q_item.node_a) * NODES + 32'(q_item.node_b));
                    ba_next  = AW'(32'(q_item.node_b) * NODES + 32'(q_item.node_a));
                    row_next = AW'(32'(q_item.node_a) * NODES);
                    w_next          = q_item.weight[SW-1:0];
                    scan_next       = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    if (q_item.op == uams_pkg::OP_BAD || q_item.op == uams_pkg::OP_UNK)
                    begin
                        state_next = ST_ONE;
                    end
                    else if (q_item.op == uams_pkg::OP_NBR)
                    begin
                        state_next = ST_N_RD;
                    end
                    else
                    begin
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_ONE:
            begin
                if (slot_free)
                begin
                    out_load          = 1'b1;
                    out_next.bad_node = op_reg == uams_pkg::OP_BAD;
                    out_next.last     = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_E_RD:
            begin
                rd_en      = 1'b1;
                raddr      = ab_reg;
                state_next = ST_E_CHK;
            end
            ST_E_CHK:
            begin
                wr_en      = do_wr;
                waddr      = ab_reg;
                wdata      = new_w;
                new_w_next = new_w;
                do_wr_next = do_wr;
                if (do_wr && rdata_reg == '0)
                begin
                    edge_next = edge_reg + TW'(1);
                end
                else if (do_wr && new_w == '0)
                begin
                    edge_next = edge_reg - TW'(1);
                end
                state_next = ST_E_WR2;
            end
            ST_E_WR2:
            begin
                // mirror entry; rewriting it while the output stalls is harmless
                wr_en = do_wr_reg;
                waddr = ba_reg;
                wdata = new_w_reg;
                if (slot_free)
                begin
                    out_load              = 1'b1;
                    wsel                  = new_w_reg;
                    out_next.edge_present = new_w_reg != '0;
                    out_next.last         = 1'b1;
                    do_wr_next            = 1'b0;
                    state_next            = ST_IDLE;
                end
            end
            ST_N_RD:
            begin
                rd_en      = 1'b1;
                raddr      = row_reg + AW'(scan_reg);
                state_next = ST_N_CHK;
            end
            ST_N_CHK:
            begin
                // a new hit pushes the held one out; wait if the output is busy
                if (!(hit && pend_valid_reg && !slot_free))
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load                = 1'b1;
                            wsel                    = pend_w_reg;
                            out_next.edge_present   = 1'b1;
                            out_next.neighbor_valid = 1'b1;
                            out_next.neighbor_node  = pend_node_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_node_next  = scan_node;
                        pend_w_next     = rdata_reg;
                        cnt_next        = cnt_reg + CW'(1);
                    end
                    if ((hit && cnt_reg == CW'(uams_pkg::MAX_RESULTS - 1)) || scan_end)
                    begin
                        state_next = ST_N_FIN;
                    end
                    else
                    begin
                        scan_next  = scan_reg + LW'(1);
                        state_next = ST_N_RD;
                    end
                end
            end
            ST_N_FIN:
            begin
                if (slot_free)
                begin
                    out_load                = 1'b1;
                    out_next.last           = 1'b1;
                    wsel                    = pend_valid_reg ? pend_w_reg : '0;
                    out_next.edge_present   = pend_valid_reg;
                    out_next.neighbor_valid = pend_valid_reg;
                    out_next.neighbor_node  = pend_valid_reg ? pend_node_reg : '0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_next.weight_out = wsel_ext;
        out_next.edge_total = edge_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            clr_reg        <= '0;
            scan_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            do_wr_reg      <= 1'b0;
            edge_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            scan_reg       <= scan_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            do_wr_reg      <= do_wr_next;
            edge_reg       <= edge_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ab_reg        <= ab_next;
        ba_reg        <= ba_next;
        row_reg       <= row_next;
        w_reg         <= w_next;
        new_w_reg     <= new_w_next;
        pend_node_reg <= pend_node_next;
        pend_w_reg    <= pend_w_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    // single-port weight matrix, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/undirected_adjacency_matrix_store.sv
`timescale 1ns / 1ps
// Top level of the undirected adjacency matrix store: APB register,
// stream packing, front/back instances. Depends on uams_pkg, uams_front, uams_back.
//
// Usage
//   Requests come in on the s_ stream, one per transaction, the kind in
//   s_tuser: add, delete or set an edge weight, get an edge, or list the
//   neighbors of a node. Each request yields one or more result transactions
//   on the m_ stream; m_tlast marks the final result of a request. A listing
//   yields one result per neighbor (at most 16), or one empty result.
//   active_nodes sits at APB address 0; write it only while no request is
//   in flight.
// Operation
//   Edits and gets pass the back end through read, check and mirror-write
//   states; rejected and unknown requests through a single result state.
//   A listing walks the row entry by entry, a read state then a check state
//   per entry, through the single matrix memory port, up to the last active
//   node or the sixteenth neighbor. A 2-entry request queue decouples the
//   input from the back end, and a result register lets the next request
//   start while a result waits.
// Reset
//   After reset the back end zeroes all NODES*NODES matrix entries (256 by
//   default) one entry per cycle; s_tready stays low meanwhile.
//   A stalled m_tready holds the result and, once the queue fills, s_tready.
module undirected_adjacency_matrix_store #(
    parameter int NODES       = uams_pkg::NODES_DEF,
    parameter int WEIGHT_BITS = uams_pkg::WEIGHT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // kind[2:0]
    input  logic [23:0] s_tdata,   // node_a[3:0], node_b[7:4], weight_in[23:8]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // edge_present[0], weight_out[16:1], neighbor_valid[17],
                                   // neighbor_node[21:18], edge_total[29:22]
    output logic        m_tuser,   // bad_node
    output logic        m_tlast    // last
);

    localparam int LW = $clog2(NODES + 1);
    localparam int AW = uams_pkg::ACTIVE_W;

    logic [AW-1:0]  active_reg;
    logic [LW-1:0]  lim;
    logic           cfg_wr;
    logic           clearing;
    logic           q_valid;
    logic           q_pop;
    uams_pkg::req_t q_item;
    uams_pkg::res_t res;

    // register write completes on the access cycle; pready is tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == uams_pkg::REG_ACTIVE);
    assign prdata = (paddr[2] == uams_pkg::REG_ACTIVE) ? 32'(active_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= uams_pkg::ACTIVE_RESET;
        end
        else if (cfg_wr)
        begin
            active_reg <= pwdata[AW-1:0];
        end
    end

    // effective node count: active_nodes saturated to the matrix size
    assign lim = (32'(active_reg) > NODES) ? LW'(NODES) : LW'(active_reg);

    uams_front #(
        .NODES (NODES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .lim      (lim),
        .hold     (clearing),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    uams_back #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .lim       (lim),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {2'b00, res.edge_total, res.neighbor_node, res.neighbor_valid,
                      res.weight_out, res.edge_present};
    assign m_tuser = res.bad_node;
    assign m_tlast = res.last;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for undirected_adjacency_matrix_store.
// Depends on uams_pkg and the RTL top level; predicts every result transaction.
module testbench;

    localparam int NODES       = uams_pkg::NODES_DEF;
    localparam int PHASE_ITEMS = 29;
    // worst request: full row walk plus queue and result register
    localparam int SETTLE      = 2 * NODES + 20;
    localparam int WATCHDOG    = 4000;

    // reserved request kinds, answered with an empty result
    localparam logic [uams_pkg::KIND_W-1:0] KIND_RSV_FIRST = 3'd5;
    localparam logic [uams_pkg::KIND_W-1:0] KIND_RSV_LAST  = {uams_pkg::KIND_W{1'b1}};

    // ------------------------------------------------------------------
    // Edge store model and result queue
    // ------------------------------------------------------------------
    class edge_store_sb;
        logic [uams_pkg::WOUT_W-1:0]   wmat [NODES][NODES];
        logic [uams_pkg::TOTAL_W-1:0]  edge_count;
        logic [uams_pkg::ACTIVE_W-1:0] active;
        uams_pkg::res_t                pending_results [$];
        int                            errors;
        int                            n_requests;
        int                            n_results;
        int                            n_listings;
        int                            n_rejected;

        function new();
            for (int i = 0; i < NODES; i++)
                for (int j = 0; j < NODES; j++)
                    wmat[i][j] = '0;
            edge_count = '0;
            active     = uams_pkg::ACTIVE_RESET;
            errors     = 0;
            n_requests = 0;
            n_results  = 0;
            n_listings = 0;
            n_rejected = 0;
        endfunction

        function void set_active(logic [uams_pkg::ACTIVE_W-1:0] value);
            active = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void push_result(logic present, logic [uams_pkg::WOUT_W-1:0] w, logic nv,
                                  logic [uams_pkg::NODE_W-1:0] nn, logic bad, logic lst);
            uams_pkg::res_t r;
            r.edge_present   = present;
            r.weight_out     = w;
            r.neighbor_valid = nv;
            r.neighbor_node  = nn;
            r.edge_total     = edge_count;
            r.bad_node       = bad;
            r.last           = lst;
            pending_results = {pending_results, r};
        endfunction

        // Accepted request: update the matrix and queue what it must produce.
        function void note_request(logic [uams_pkg::KIND_W-1:0] kind,
                                   logic [uams_pkg::NODE_W-1:0] a,
                                   logic [uams_pkg::NODE_W-1:0] b,
                                   logic [uams_pkg::WIN_W-1:0] w);
            int lim;
            int hits;
            int k;
            n_requests++;
            lim = (active > NODES) ? NODES : active;
            if (kind > uams_pkg::KIND_NBR)
            begin
                push_result(1'b0, '0, 1'b0, '0, 1'b0, 1'b1);
                return;
            end
            if (a >= lim || (kind != uams_pkg::KIND_NBR && b >= lim))
            begin
                n_rejected++;
                push_result(1'b0, '0, 1'b0, '0, 1'b1, 1'b1);
                return;
            end
            if (kind == uams_pkg::KIND_NBR)
            begin
                n_listings++;
                hits = 0;
                for (int i = 0; i < lim; i++)
                    if (wmat[a][i] != '0)
                        hits++;
                if (hits > uams_pkg::MAX_RESULTS)
                    hits = uams_pkg::MAX_RESULTS;
                if (hits == 0)
                begin
                    push_result(1'b0, '0, 1'b0, '0, 1'b0, 1'b1);
                    return;
                end
                k = 0;
                for (int i = 0; i < lim && k < hits; i++)
                    if (wmat[a][i] != '0)
                    begin
                        push_result(1'b1, wmat[a][i], 1'b1, uams_pkg::NODE_W'(i), 1'b0,
                                    k == hits - 1);
                        k++;
                    end
                return;
            end
            if (kind == uams_pkg::KIND_ADD ||
                (kind == uams_pkg::KIND_SET && wmat[a][b] == '0))
            begin
                // zero weight never creates an edge
                if (wmat[a][b] == '0 && w != '0)
                begin
                    wmat[a][b] = w;
                    wmat[b][a] = w;
                    edge_count = edge_count + 1'b1;
                end
            end
            else if (kind == uams_pkg::KIND_DEL || (kind == uams_pkg::KIND_SET && w == '0))
            begin
                if (wmat[a][b] != '0)
                begin
                    wmat[a][b] = '0;
                    wmat[b][a] = '0;
                    edge_count = edge_count - 1'b1;
                end
            end
            else if (kind == uams_pkg::KIND_SET)
            begin
                wmat[a][b] = w;
                wmat[b][a] = w;
            end
            push_result(wmat[a][b] != '0, wmat[a][b], 1'b0, '0, 1'b0, 1'b1);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(uams_pkg::res_t act);
            uams_pkg::res_t exp_r;
            n_results++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, act);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            compare_field("edge_present",   exp_r.edge_present,   act.edge_present);
            compare_field("weight_out",     exp_r.weight_out,     act.weight_out);
            compare_field("neighbor_valid", exp_r.neighbor_valid, act.neighbor_valid);
            compare_field("neighbor_node",  exp_r.neighbor_node,  act.neighbor_node);
            compare_field("edge_total",     exp_r.edge_total,     act.edge_total);
            compare_field("bad_node",       exp_r.bad_node,       act.bad_node);
            compare_field("last",           exp_r.last,           act.last);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    undirected_adjacency_matrix_store u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    edge_store_sb sb = new();

    int cfg_errors = 0;
    int idle_cycles = 0;
    bit rx_calm = 1'b0;     // when set the result side never stalls
    bit tx_calm = 1'b0;     // when set requests go back to back
    int rx_stall_left = 0;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // request data layout: node_a[3:0], node_b[7:4], weight_in[23:8]; kind in tuser
    function automatic logic [23:0] pack_req(logic [uams_pkg::NODE_W-1:0] a,
                                             logic [uams_pkg::NODE_W-1:0] b,
                                             logic [uams_pkg::WIN_W-1:0] w);
        return {w, b, a};
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both streams are sampled here at the rising edge, the
    // request side first so a request is always noted before its results.
    // The watchdog counts edges with no transaction on either stream.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        uams_pkg::res_t act;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[3:0], s_tdata[7:4], s_tdata[23:8]);
            if (m_tvalid && m_tready)
            begin
                act.edge_present   = m_tdata[0];
                act.weight_out     = m_tdata[16:1];
                act.neighbor_valid = m_tdata[17];
                act.neighbor_node  = m_tdata[21:18];
                act.edge_total     = m_tdata[29:22];
                act.bad_node       = m_tuser;
                act.last           = m_tlast;
                sb.check_result(act);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG)
        begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG);
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side back-pressure: random stalls unless calm.
    always @(posedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (rx_calm || $urandom_range(0, 99) < 70)
            m_tready <= 1'b1;
        else
        begin
            rx_stall_left <= pick_gap();
            m_tready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // One request transaction, then an optional gap with tvalid low.
    task automatic send_req(logic [uams_pkg::KIND_W-1:0] kind,
                            logic [uams_pkg::NODE_W-1:0] a,
                            logic [uams_pkg::NODE_W-1:0] b,
                            logic [uams_pkg::WIN_W-1:0] w);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        s_tuser  <= kind;
        s_tdata  <= pack_req(a, b, w);
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let the block run dry: every expected result in, then settle time.
    // It first waits on the clock so the monitor has noted the last accepted request.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write of active_nodes followed by a read back.
    task automatic set_active_nodes(logic [uams_pkg::ACTIVE_W-1:0] value);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * uams_pkg::REG_ACTIVE);
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_active(value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rd = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[uams_pkg::ACTIVE_W-1:0] !== value)
        begin
            $display("%0t: active_nodes read back, expected %0h, actual %0h",
                     $time, value, rd[uams_pkg::ACTIVE_W-1:0]);
            cfg_errors++;
        end
    endtask

    // Random request aimed mostly at nodes in range so edits actually land.
    task automatic send_random_req(int lim);
        logic [uams_pkg::KIND_W-1:0] kind;
        logic [uams_pkg::NODE_W-1:0] a;
        logic [uams_pkg::NODE_W-1:0] b;
        logic [uams_pkg::WIN_W-1:0]  w;
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)
            kind = uams_pkg::KIND_ADD;
        else if (r < 37)
            kind = uams_pkg::KIND_DEL;
        else if (r < 57)
            kind = uams_pkg::KIND_SET;
        else if (r < 75)
            kind = uams_pkg::KIND_GET;
        else if (r < 93)
            kind = uams_pkg::KIND_NBR;
        else
            kind = uams_pkg::KIND_W'($urandom_range(KIND_RSV_FIRST, KIND_RSV_LAST));
        a = (lim > 0 && $urandom_range(0, 99) < 85)
            ? uams_pkg::NODE_W'($urandom_range(0, lim - 1))
            : uams_pkg::NODE_W'($urandom_range(0, NODES - 1));
        b = (lim > 0 && $urandom_range(0, 99) < 85)
            ? uams_pkg::NODE_W'($urandom_range(0, lim - 1))
            : uams_pkg::NODE_W'($urandom_range(0, NODES - 1));
        r = $urandom_range(0, 99);
        if (r < 15)
            w = '0;
        else if (r < 25)
            w = '1;
        else if (r < 30)
            w = uams_pkg::WIN_W'(1);
        else
            w = uams_pkg::WIN_W'($urandom);
        send_req(kind, a, b, w);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [uams_pkg::ACTIVE_W-1:0] settings [10];
        int lim;
        settings = '{5'd16, 5'd1, 5'd2, 5'd5, 5'd0, 5'd31, 5'd17, 5'd8, 5'd3, 5'd16};
        settings[9] = uams_pkg::ACTIVE_W'($urandom_range(1, 16));

        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the full node range.
        set_active_nodes(5'd16);
        send_req(uams_pkg::KIND_NBR, 4'd5, 4'd0, 16'h0000);    // empty listing
        send_req(uams_pkg::KIND_ADD, 4'd2, 4'd2, 16'h0000);    // zero weight add is a no-op
        send_req(uams_pkg::KIND_ADD, 4'd0, 4'd0, 16'hFFFF);    // self loop, max weight
        send_req(uams_pkg::KIND_ADD, 4'd0, 4'd15, 16'h0001);
        send_req(uams_pkg::KIND_ADD, 4'd15, 4'd0, 16'h0005);   // edge exists, no change
        send_req(uams_pkg::KIND_SET, 4'd0, 4'd15, 16'h8000);   // rewrite
        send_req(uams_pkg::KIND_GET, 4'd15, 4'd0, 16'h0000);   // mirrored entry
        send_req(uams_pkg::KIND_DEL, 4'd15, 4'd0, 16'h0000);
        send_req(uams_pkg::KIND_SET, 4'd3, 4'd7, 16'h0000);    // set zero with no edge
        send_req(uams_pkg::KIND_SET, 4'd3, 4'd7, 16'h1234);    // set acting as add
        send_req(uams_pkg::KIND_SET, 4'd7, 4'd3, 16'h0000);    // set acting as delete
        send_req(KIND_RSV_LAST, 4'd15, 4'd15, 16'hFFFF);
        // Fill row 0 completely so the listing hits the result cap.
        for (int i = 1; i < NODES; i++)
            send_req(uams_pkg::KIND_ADD, 4'd0, uams_pkg::NODE_W'(i),
                     uams_pkg::WIN_W'(i * 16'h1111));
        send_req(uams_pkg::KIND_NBR, 4'd0, 4'd0, 16'h0000);
        send_req(uams_pkg::KIND_NBR, 4'd15, 4'd9, 16'h0000);
        drain_results();

        // Random phases, each under its own node count.
        for (int ph = 0; ph < 10; ph++)
        begin
            set_active_nodes(settings[ph]);
            lim = (settings[ph] > NODES) ? NODES : settings[ph];
            tx_calm = (ph == 4);
            rx_calm = (ph == 4 || ph == 7);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender holds off mid-phase until the block is empty
                if (n == PHASE_ITEMS / 2 && ph % 3 == 0)
                    drain_results();
                send_random_req(lim);
            end
            drain_results();
        end

        $display("Ran %0d requests (%0d listings, %0d rejected) under 11 node counts,",
                 sb.n_requests, sb.n_listings, sb.n_rejected);
        $display("%0d result transactions checked against the predicted matrix.",
                 sb.n_results);
        if (sb.errors == 0 && cfg_errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/uams_pkg.sv
rtl/core/uams_front.sv
rtl/core/uams_back.sv
rtl/core/undirected_adjacency_matrix_store.sv
tb/sv/testbench.sv
